### hdl/i2cps_pkg.sv
// i2cps_pkg.sv: shared types and codes of the i2c master pin sequencer
`default_nettype none

package i2cps_pkg;

  // function codes carried by an input item
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_STOP  = 3'd2;
  localparam logic [2:0] FUNC_SEND  = 3'd3;
  localparam logic [2:0] FUNC_RECV  = 3'd4;
  localparam logic [2:0] FUNC_SACK  = 3'd5;
  localparam logic [2:0] FUNC_RACK  = 3'd6;

  // last phase of each operation
  localparam logic [4:0] LAST_START = 5'd3;
  localparam logic [4:0] LAST_STOP  = 5'd2;
  localparam logic [4:0] LAST_SEND  = 5'd23;
  localparam logic [4:0] LAST_RECV  = 5'd16;
  localparam logic [4:0] LAST_SHORT = 5'd2;

  // bit slot positions of send byte and send ack
  localparam logic [1:0] SLOT_DATA = 2'd0;
  localparam logic [1:0] SLOT_RISE = 2'd1;
  localparam logic [1:0] SLOT_FALL = 2'd2;

  // running operation
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_SEND  = 3'd3,
    OP_RECV  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       rejected;
  } out_item_t;

  // sequencer state
  typedef struct packed {
    op_e        op;
    logic [4:0] phase;
    logic [1:0] slot;
    logic [7:0] shift_out;
    logic [7:0] shift_in;
    logic       scl;
    logic       sda;
    logic       ack_seen;
  } seq_state_t;

endpackage

`default_nettype wire

### hdl/i2cps_if.sv
// i2cps_if.sv: valid/ready channels for input and result items
`default_nettype none

interface i2cps_in_if
  import i2cps_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface i2cps_out_if
  import i2cps_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### hdl/i2cps_step.sv
// i2cps_step.sv: one pin change or command load, from current state and one item
`default_nettype none

module i2cps_step
  import i2cps_pkg::*;
(
  input  seq_state_t st_i,
  input  in_item_t   item_i,
  output seq_state_t st_o,
  output out_item_t  res_o
);

  seq_state_t st_n;
  logic       last;
  logic       done;
  logic       rej;

  always_comb begin
    st_n = st_i;
    last = 1'b0;
    done = 1'b0;
    rej  = 1'b0;

    if (item_i.func == FUNC_TICK) begin
      // tick: next pin change of the running operation
      if (st_i.op != OP_IDLE) begin
        unique case (st_i.op) inside
          OP_START: begin
            case (st_i.phase)
              5'd0:    st_n.sda = 1'b1;
              5'd1:    st_n.scl = 1'b1;
              5'd2:    st_n.sda = 1'b0;
              default: st_n.scl = 1'b0;
            endcase
            last = (st_i.phase >= LAST_START);
          end
          OP_STOP: begin
            case (st_i.phase)
              5'd0:    st_n.sda = 1'b0;
              5'd1:    st_n.scl = 1'b1;
              default: st_n.sda = 1'b1;
            endcase
            last = (st_i.phase >= LAST_STOP);
          end
          OP_SEND, OP_SACK: begin
            case (st_i.slot)
              SLOT_DATA: begin
                st_n.sda       = st_i.shift_out[7];
                st_n.shift_out = {st_i.shift_out[6:0], 1'b0};
              end
              SLOT_RISE: st_n.scl = 1'b1;
              default:   st_n.scl = 1'b0;
            endcase
            st_n.slot = (st_i.slot == SLOT_FALL) ? SLOT_DATA : st_i.slot + 2'd1;
            last = (st_i.op == OP_SEND) ? (st_i.phase >= LAST_SEND)
                                        : (st_i.phase >= LAST_SHORT);
          end
          OP_RECV: begin
            if (st_i.phase == 5'd0) begin
              st_n.sda = 1'b1;
            end else if (st_i.phase[0]) begin
              st_n.scl = 1'b1;
            end else begin
              st_n.shift_in = {st_i.shift_in[6:0], item_i.sda_in};
              st_n.scl      = 1'b0;
            end
            last = (st_i.phase >= LAST_RECV);
          end
          OP_RACK: begin
            case (st_i.phase)
              5'd0: st_n.sda = 1'b1;
              5'd1: st_n.scl = 1'b1;
              default: begin
                st_n.ack_seen = item_i.sda_in;
                st_n.scl      = 1'b0;
              end
            endcase
            last = (st_i.phase >= LAST_SHORT);
          end
          default: last = 1'b0;
        endcase

        // end of operation or step to next phase
        if (last) begin
          st_n.op    = OP_IDLE;
          st_n.phase = '0;
          done       = 1'b1;
        end else begin
          st_n.phase = st_i.phase + 5'd1;
        end
      end
    end else if (item_i.func >= FUNC_START && item_i.func <= FUNC_RACK) begin
      // command: load when idle, reject when busy
      if (st_i.op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        st_n.op    = op_e'(item_i.func);
        st_n.phase = '0;
        st_n.slot  = SLOT_DATA;
        if (item_i.func == FUNC_SEND) begin
          st_n.shift_out = item_i.tx_byte;
        end else if (item_i.func == FUNC_SACK) begin
          st_n.shift_out = {item_i.ack_out, 7'd0};
        end
      end
    end
  end

  assign st_o = st_n;

  // result item
  always_comb begin
    res_o.scl      = st_n.scl;
    res_o.sda_out  = st_n.sda;
    res_o.busy_res = (st_n.op != OP_IDLE);
    res_o.done_res = done;
    res_o.rx_byte  = st_n.shift_in;
    res_o.ack_in   = st_n.ack_seen;
    res_o.rejected = rej;
  end

endmodule

`default_nettype wire

### hdl/i2c_master_pin_sequencer_unit.sv
// i2c_master_pin_sequencer_unit.sv: top level of the i2c master pin sequencer
//
// Input channel in_i carries command and tick items; output channel out_o
// returns exactly one result item for every input item, in order.
// A command (start, stop, send byte, receive byte, send ack, receive ack)
// loads an operation; each tick item then makes one SCL or SDA change.
// The result holds the pin levels after the item, busy, done, the receive
// shift register, the last sampled acknowledge and a rejected flag for a
// command given while busy.
// The result is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle while out_o does not stall; the state update is a single
// combinational step between the sequencer state register and the result
// register.
// The output register frees up in the cycle it is taken, so in_i.ready is
// high whenever the result register is empty or out_o.ready is high; while
// the receiver stalls, the result holds and no new item is accepted.
// Reset: no result pending, operation idle, both pins high (bus idle),
// shift registers and acknowledge cleared.
`default_nettype none

module i2c_master_pin_sequencer_unit
  import i2cps_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  i2cps_in_if.sink    in_i,
  i2cps_out_if.source out_o
);

  seq_state_t st_q;
  seq_state_t st_d;
  out_item_t  res_q;
  out_item_t  res_d;
  logic       out_valid_q;
  logic       in_ready;
  logic       in_fire;

  // handshake
  assign in_ready = ~out_valid_q | out_o.ready;
  assign in_fire  = in_i.valid & in_ready;
  assign in_i.ready = in_ready;

  // next state and result for this item
  i2cps_step u_step (
    .st_i   (st_q),
    .item_i (in_i.item),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.op        <= OP_IDLE;
      st_q.phase     <= '0;
      st_q.slot      <= SLOT_DATA;
      st_q.shift_out <= '0;
      st_q.shift_in  <= '0;
      st_q.scl       <= 1'b1;
      st_q.sda       <= 1'b1;
      st_q.ack_seen  <= 1'b0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = res_q;

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top.sv: self-checking testbench of the i2c master pin sequencer
`timescale 1ns / 1ps

module tb_top;
  import i2cps_pkg::*;

  // function code seven does nothing at all
  localparam logic [2:0] FUNC_NONE = 3'd7;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned TIMEOUT_NS = 5_000_000;

  typedef struct {
    in_item_t    item;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          hold;
  } stim_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  in_item_t in_item = '0;
  logic     out_ready = 1'b0;

  i2cps_in_if  in_ch ();
  i2cps_out_if out_ch ();

  assign in_ch.valid  = in_valid;
  assign in_ch.item   = in_item;
  assign out_ch.ready = out_ready;

  i2c_master_pin_sequencer_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_t       pending_cmds_q[$];
  out_item_t   expected_pins_q[$];
  int unsigned stall_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned error_cnt = 0;
  int unsigned report_cnt = 0;

  // shadow of the sequencer state, starting from the idle bus
  op_e        bus_op = OP_IDLE;
  logic [4:0] bus_phase = '0;
  logic [7:0] bus_shift_out = '0;
  logic [7:0] bus_shift_in = '0;
  logic       bus_scl = 1'b1;
  logic       bus_sda = 1'b1;
  logic       bus_ack = 1'b0;

  // applies one item to the shadow state and returns the pin levels it leaves
  function automatic out_item_t next_pins(in_item_t it);
    out_item_t  r;
    logic [4:0] last;
    logic [1:0] slot;
    logic       done;
    logic       rej;
    done = 1'b0;
    rej  = 1'b0;
    last = '0;
    slot = 2'(bus_phase % 5'd3);
    if (it.func == FUNC_TICK) begin
      if (bus_op != OP_IDLE) begin
        case (bus_op)
          OP_START: begin
            case (bus_phase)
              5'd0: bus_sda = 1'b1;
              5'd1: bus_scl = 1'b1;
              5'd2: bus_sda = 1'b0;
              default: bus_scl = 1'b0;
            endcase
            last = LAST_START;
          end
          OP_STOP: begin
            case (bus_phase)
              5'd0: bus_sda = 1'b0;
              5'd1: bus_scl = 1'b1;
              default: bus_sda = 1'b1;
            endcase
            last = LAST_STOP;
          end
          OP_SEND, OP_SACK: begin
            case (slot)
              SLOT_DATA: begin
                bus_sda = bus_shift_out[7];
                bus_shift_out = {bus_shift_out[6:0], 1'b0};
              end
              SLOT_RISE: bus_scl = 1'b1;
              default: bus_scl = 1'b0;
            endcase
            last = (bus_op == OP_SEND) ? LAST_SEND : LAST_SHORT;
          end
          OP_RECV: begin
            if (bus_phase == 5'd0) begin
              bus_sda = 1'b1;
            end else if (bus_phase[0]) begin
              bus_scl = 1'b1;
            end else begin
              bus_shift_in = {bus_shift_in[6:0], it.sda_in};
              bus_scl = 1'b0;
            end
            last = LAST_RECV;
          end
          default: begin
            case (bus_phase)
              5'd0: bus_sda = 1'b1;
              5'd1: bus_scl = 1'b1;
              default: begin
                bus_ack = it.sda_in;
                bus_scl = 1'b0;
              end
            endcase
            last = LAST_SHORT;
          end
        endcase
        if (bus_phase >= last) begin
          bus_op = OP_IDLE;
          bus_phase = '0;
          done = 1'b1;
        end else begin
          bus_phase = bus_phase + 5'd1;
        end
      end
    end else if (it.func != FUNC_NONE) begin
      if (bus_op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        bus_op = op_e'(it.func);
        bus_phase = '0;
        if (it.func == FUNC_SEND) bus_shift_out = it.tx_byte;
        else if (it.func == FUNC_SACK) bus_shift_out = {it.ack_out, 7'd0};
      end
    end
    r.scl      = bus_scl;
    r.sda_out  = bus_sda;
    r.busy_res = (bus_op != OP_IDLE);
    r.done_res = done;
    r.rx_byte  = bus_shift_in;
    r.ack_in   = bus_ack;
    r.rejected = rej;
    return r;
  endfunction

  // driver: offers queued items, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready) expected_pins_q.push_back(next_pins(in_item));
      if (!in_valid || in_ch.ready) begin
        if (pending_cmds_q.size() != 0 &&
            $urandom_range(99) >= pending_cmds_q[0].gap_pct) begin
          in_valid  <= 1'b1;
          in_item   <= pending_cmds_q[0].item;
          stall_pct <= pending_cmds_q[0].stall_pct;
          if (pending_cmds_q[0].hold) hold_seq <= hold_seq + 1;
          void'(pending_cmds_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor: compares each accepted result with the oldest expectation
  out_item_t exp_r;
  out_item_t got_r;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ready) begin
      got_r = out_ch.item;
      if (expected_pins_q.size() == 0) begin
        error_cnt = error_cnt + 1;
        if (report_cnt < 10) begin
          report_cnt = report_cnt + 1;
          $display("unexpected result at %0t: scl=%0b sda=%0b busy=%0b done=%0b",
                   $realtime, got_r.scl, got_r.sda_out, got_r.busy_res, got_r.done_res);
        end
      end else begin
        exp_r = expected_pins_q.pop_front();
        if (got_r.scl !== exp_r.scl || got_r.sda_out !== exp_r.sda_out ||
            got_r.busy_res !== exp_r.busy_res || got_r.done_res !== exp_r.done_res ||
            got_r.rx_byte !== exp_r.rx_byte || got_r.ack_in !== exp_r.ack_in ||
            got_r.rejected !== exp_r.rejected) begin
          error_cnt = error_cnt + 1;
          if (report_cnt < 10) begin
            report_cnt = report_cnt + 1;
            $display("mismatch at %0t: scl/sda/busy/done/rx/ack/rej", $realtime);
            $display("  expected %0b %0b %0b %0b %02h %0b %0b", exp_r.scl, exp_r.sda_out,
                     exp_r.busy_res, exp_r.done_res, exp_r.rx_byte, exp_r.ack_in,
                     exp_r.rejected);
            $display("  actual   %0b %0b %0b %0b %02h %0b %0b", got_r.scl, got_r.sda_out,
                     got_r.busy_res, got_r.done_res, got_r.rx_byte, got_r.ack_in,
                     got_r.rejected);
          end
        end
      end
    end
  end

  // stimulus shaping state, tracks how many ticks the running operation needs
  int unsigned ticks_left = 0;
  int unsigned counted = 0;
  int unsigned cur_gap = 0;
  int unsigned cur_stall = 0;
  bit          hold_next = 1'b0;

  task automatic queue_item(logic [2:0] func, logic [7:0] txb, logic ackv, logic sdav);
    stim_t s;
    s.item.func    = func;
    s.item.tx_byte = txb;
    s.item.ack_out = ackv;
    s.item.sda_in  = sdav;
    s.gap_pct      = cur_gap;
    s.stall_pct    = cur_stall;
    s.hold         = hold_next;
    hold_next      = 1'b0;
    pending_cmds_q.push_back(s);
    if (func == FUNC_TICK) begin
      if (ticks_left > 0) begin
        ticks_left--;
        counted++;
      end
    end else if (func != FUNC_NONE) begin
      counted++;
      if (ticks_left == 0) begin
        case (func)
          FUNC_START: ticks_left = LAST_START + 1;
          FUNC_STOP:  ticks_left = LAST_STOP + 1;
          FUNC_SEND:  ticks_left = LAST_SEND + 1;
          FUNC_RECV:  ticks_left = LAST_RECV + 1;
          default:    ticks_left = LAST_SHORT + 1;
        endcase
      end
    end
  endtask

  initial begin
    int unsigned seg;
    int unsigned drain;
    logic [7:0]  txb;
    bit          hold_done;
    hold_done = 1'b0;

    // directed: idle tick, code seven, each command code, rejected commands
    queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    queue_item(FUNC_NONE, 8'hFF, 1'b1, 1'b1);
    queue_item(FUNC_START, 8'hFF, 1'b1, 1'b1);
    queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b1);
    queue_item(FUNC_STOP, 8'h00, 1'b0, 1'b0);
    repeat (3) queue_item(FUNC_TICK, 8'hFF, 1'b1, 1'b0);
    queue_item(FUNC_STOP, 8'h00, 1'b0, 1'b0);
    repeat (3) queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b1);
    queue_item(FUNC_SACK, 8'h00, 1'b1, 1'b0);
    repeat (3) queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    queue_item(FUNC_RACK, 8'hFF, 1'b0, 1'b1);
    repeat (3) queue_item(FUNC_TICK, 8'h00, 1'b0, 1'b0);
    queue_item(FUNC_SACK, 8'hFF, 1'b0, 1'b1);
    queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b1);
    queue_item(FUNC_RACK, 8'h00, 1'b0, 1'b1);
    repeat (2) queue_item(FUNC_TICK, 8'h00, 1'b1, 1'b1);
    queue_item(FUNC_SEND, 8'h00, 1'b0, 1'b0);
    queue_item(FUNC_RECV, 8'hFF, 1'b1, 1'b1);

    // random: mostly complete operations with random content, some noise
    counted = 0;
    while (counted < ITEM_TARGET) begin
      seg = counted * 4 / ITEM_TARGET;
      case (seg)
        0: begin cur_gap = 0; cur_stall = 0; end
        1: begin cur_gap = 66; cur_stall = 0; end
        2: begin cur_gap = 0; cur_stall = 66; end
        default: begin cur_gap = 24; cur_stall = 24; end
      endcase
      if (seg == 0 && counted > 100 && !hold_done) begin
        hold_next = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(99) < 85) begin
        if (ticks_left == 0) begin
          case ($urandom_range(3))
            0: txb = 8'h00;
            1: txb = 8'hFF;
            default: txb = 8'($urandom);
          endcase
          queue_item(3'($urandom_range(6, 1)), txb, 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end
        while (ticks_left > 0) begin
          if ($urandom_range(99) < 4)
            queue_item(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
          queue_item(FUNC_TICK, 8'($urandom), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
        end
      end else begin
        queue_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all items to go in and all results to come back
    while (pending_cmds_q.size() != 0 || in_valid) @(negedge clk);
    drain = 0;
    while (expected_pins_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (4) @(negedge clk);
    error_cnt = error_cnt + expected_pins_q.size();

    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
